### hdl/fpi_pkg.sv
// ============================================================================
// fpi_pkg: shared types and constants of the four-point sample interpolator
// Mode and select codes, coefficient tables, lane and divider types.
// ============================================================================
`default_nettype none

package fpi_pkg;

    localparam int FRAC_W  = 16;
    localparam int SAMP_W  = 24;
    localparam int WGT_W   = 24;
    localparam int VAL_W   = 26;
    localparam int LANES   = 4;
    localparam int IN_W    = 128;
    localparam int OUT_W   = 32;

    localparam int DIV_N_W     = 53;
    localparam int DIV_D_W     = 28;
    localparam int DIV_Q_W     = 25;
    localparam int DIV_STAGES  = 5;
    localparam int DIV_STEPS   = DIV_Q_W / DIV_STAGES;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_ROUND  = 3'd1;
    localparam logic [2:0] MODE_LINEAR = 3'd2;
    localparam logic [2:0] MODE_KEYS   = 3'd3;
    localparam logic [2:0] MODE_BSPL   = 3'd4;
    localparam logic [2:0] MODE_OMOMS  = 3'd5;
    localparam logic [2:0] MODE_NNA    = 3'd6;

    localparam logic [14:0] LEN_RESET = 15'd256;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    localparam logic [1:0] SEL_SIMPLE = 2'd0;
    localparam logic [1:0] SEL_POLY   = 2'd1;
    localparam logic [1:0] SEL_NNA    = 2'd2;

    localparam logic [2:0] SV_NEG1 = 3'd0;
    localparam logic [2:0] SV_ZERO = 3'd1;
    localparam logic [2:0] SV_AT   = 3'd2;
    localparam logic [2:0] SV_NEXT = 3'd3;
    localparam logic [2:0] SV_LIN  = 3'd4;

    localparam logic [1:0] LANE_BEFORE = 2'd0;
    localparam logic [1:0] LANE_AT     = 2'd1;
    localparam logic [1:0] LANE_AFTER  = 2'd2;
    localparam logic [1:0] LANE_AFTER2 = 2'd3;

    // [kind][lane][power of t]; kind 0 Keys, 1 B-spline, 2 O-MOMS
    localparam logic signed [7:0] POLY_C [4][4][4] = '{
        '{ '{8'sd0, -8'sd1, 8'sd2, -8'sd1}, '{8'sd2, 8'sd0, -8'sd5, 8'sd3},
           '{8'sd0, 8'sd1, 8'sd4, -8'sd3},  '{8'sd0, 8'sd0, -8'sd1, 8'sd1} },
        '{ '{8'sd1, -8'sd3, 8'sd3, -8'sd1}, '{8'sd4, 8'sd0, -8'sd6, 8'sd3},
           '{8'sd1, 8'sd3, 8'sd3, -8'sd3},  '{8'sd0, 8'sd0, 8'sd0, 8'sd1} },
        '{ '{8'sd8, -8'sd22, 8'sd21, -8'sd7}, '{8'sd26, 8'sd3, -8'sd42, 8'sd21},
           '{8'sd8, 8'sd18, 8'sd21, -8'sd21}, '{8'sd0, 8'sd1, 8'sd0, 8'sd7} },
        '{ '{8'sd0, 8'sd0, 8'sd0, 8'sd0}, '{8'sd0, 8'sd0, 8'sd0, 8'sd0},
           '{8'sd0, 8'sd0, 8'sd0, 8'sd0}, '{8'sd0, 8'sd0, 8'sd0, 8'sd0} }
    };
    localparam logic [6:0]  POLY_HALF [4] = '{7'd2, 7'd6, 7'd42, 7'd2};
    localparam logic [6:0]  POLY_DIV2 [4] = '{7'd4, 7'd12, 7'd84, 7'd4};
    // ceil(2^30 / POLY_DIV2)
    localparam logic [28:0] POLY_RECIP [4] =
        '{29'd268435456, 29'd89478486, 29'd12782641, 29'd268435456};

    typedef logic signed [SAMP_W-1:0] t_sample;
    typedef logic signed [VAL_W-1:0]  t_value;

    typedef struct packed {
        t_value     val;
        logic [1:0] sel;
        logic       oor;
    } t_side;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic [WGT_W-1:0]  t1;
        logic [WGT_W-1:0]  t2;
        logic [WGT_W-1:0]  t3;
        logic [1:0]        kind;
    } t_lane_ctl;

    typedef struct packed {
        logic signed [50:0] poly_pp;
        logic signed [49:0] nna_pp;
        logic [24:0]        nna_w;
    } t_lane_res;

    typedef struct packed {
        logic [DIV_D_W-1:0] rem;
        logic [DIV_Q_W-1:0] low;
        logic [DIV_D_W-1:0] dvs;
        logic [DIV_Q_W-1:0] quo;
    } t_div_st;

    function automatic t_value sat_val(input logic signed [28:0] v);
        t_value res;
        if (v > 29'sd33554431) begin
            res = t_value'(26'h1FFFFFF);
        end else if (v < -29'sd33554432) begin
            res = t_value'(26'h2000000);
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/fpi_div.sv
// ============================================================================
// fpi_div: pipelined restoring divider
// Unsigned quotient, several quotient bits per stage, one beat per cycle while i_en is high.
// ============================================================================
`default_nettype none

module fpi_div import fpi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic [DIV_Q_W-1:0] o_quotient
);

    t_div_st st_in;
    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];

    function automatic t_div_st div_steps(input t_div_st s);
        logic [DIV_D_W:0] trial;
        t_div_st o;
        o = s;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {o.rem, o.low[DIV_Q_W-1]};
            if (trial >= {1'b0, o.dvs}) begin
                o.rem = DIV_D_W'(trial - {1'b0, o.dvs});
                o.quo = {o.quo[DIV_Q_W-2:0], 1'b1};
            end else begin
                o.rem = trial[DIV_D_W-1:0];
                o.quo = {o.quo[DIV_Q_W-2:0], 1'b0};
            end
            o.low = {o.low[DIV_Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        st_in.rem = i_dividend[DIV_N_W-1:DIV_Q_W];
        st_in.low = i_dividend[DIV_Q_W-1:0];
        st_in.dvs = i_divisor;
        st_in.quo = '0;
        n_st[0] = div_steps(st_in);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_st[k] = div_steps(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quotient = r_st[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### hdl/fpi_lane.sv
// ============================================================================
// fpi_lane: one sample lane
// Polynomial weight for the cubic kernels, inverse-distance weight for NNA,
// and the weighted sample products.
// ============================================================================
`default_nettype none

module fpi_lane import fpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  logic [1:0] i_lane,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_sample,
    output t_lane_res o_res
);

    // sample delay, index k holds the beat of lane stage k+1
    t_sample r_sd [7];

    // polynomial weight
    logic signed [7:0]  c [4];
    logic signed [33:0] num;
    logic [35:0]        xs;
    logic [35:0]        r4_x;
    logic [1:0]         r4_kind, r5_kind, r6_kind;
    logic [48:0]        ph;
    logic [18:0]        r5_qh, r6_qh, r7_qh;
    logic [19:0]        r5_xh;
    logic [15:0]        r5_xl;
    logic [25:0]        qc, rhw;
    logic [22:0]        r6_y;
    logic [51:0]        py;
    logic [16:0]        r7_ql;
    logic [34:0]        q;
    logic signed [26:0] wt;
    logic signed [50:0] r8_pp, r9_pp, r10_pp, r11_pp;

    // inverse-distance weight
    logic [16:0] fr, rc, m;
    logic [17:0] d;
    logic [DIV_Q_W-1:0] quo;
    logic [49:0] qq, q4q;
    logic [24:0] r_q2, r_q4, r_w;
    logic signed [49:0] r_npp;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            c[j] = POLY_C[i_ctl.kind][i_lane][j];
        end
        num = (34'(c[0]) <<< WGT_W)
            + 34'(c[1]) * $signed(34'(i_ctl.t1))
            + 34'(c[2]) * $signed(34'(i_ctl.t2))
            + 34'(c[3]) * $signed(34'(i_ctl.t3));
        // offset keeps the dividend positive, removed again below
        xs = (36'(num) << 1) + 36'(POLY_HALF[i_ctl.kind])
           + (36'(POLY_DIV2[i_ctl.kind]) << 27);
        ph  = 49'(r4_x[35:16]) * 49'(POLY_RECIP[r4_kind]);
        qc  = 26'(r5_qh) * 26'(POLY_DIV2[r5_kind]);
        rhw = 26'(r5_xh) - qc;
        py  = 52'(r6_y) * 52'(POLY_RECIP[r6_kind]);
        q   = {r7_qh, 16'h0000} + 35'(r7_ql);
        wt  = 27'(q - 35'(1 << 27));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_sample;
            for (int k = 1; k < 7; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r4_x    <= xs;
            r4_kind <= i_ctl.kind;
            r5_qh   <= ph[48:30];
            r5_xh   <= r4_x[35:16];
            r5_xl   <= r4_x[15:0];
            r5_kind <= r4_kind;
            r6_y    <= {rhw[6:0], r5_xl};
            r6_qh   <= r5_qh;
            r6_kind <= r5_kind;
            r7_ql   <= py[46:30];
            r7_qh   <= r6_qh;
            r8_pp   <= 51'(wt) * 51'(r_sd[3]);
            r9_pp   <= r8_pp;
            r10_pp  <= r9_pp;
            r11_pp  <= r10_pp;
        end
    end

    always_comb begin
        fr = 17'(i_ctl.frac);
        rc = 17'h10000 - fr;
        m  = (fr < rc) ? fr : rc;
        case (i_lane)
            LANE_BEFORE: d = 18'h10000 + 18'(fr);
            LANE_AT:     d = 18'(fr);
            LANE_AFTER:  d = 18'(rc);
            LANE_AFTER2: d = 18'h20000 - 18'(fr);
            default:     d = 18'(fr);
        endcase
        qq  = 50'(quo) * 50'(quo);
        q4q = 50'(r_q2) * 50'(r_q2);
    end

    fpi_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (DIV_N_W'(m) << WGT_W),
        .i_divisor  (DIV_D_W'(d)),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q2  <= qq[48:24];
            r_q4  <= q4q[48:24];
            r_npp <= 50'($signed({1'b0, r_q4})) * 50'(r_sd[6]);
            r_w   <= r_q4;
        end
    end

    assign o_res.poly_pp = r11_pp;
    assign o_res.nna_pp  = r_npp;
    assign o_res.nna_w   = r_w;

endmodule

`default_nettype wire

### hdl/fpi_merge.sv
// ============================================================================
// fpi_merge: lane merge
// Sums the lane products, rounds the kernel result, divides the NNA sum by
// the weight sum and picks the final value.
// ============================================================================
`default_nettype none

module fpi_merge import fpi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_lane_res i_res [LANES],
    input  t_side     i_side,
    output t_value    o_value
);

    logic signed [52:0] psum, r_pacc, pr;
    logic signed [51:0] nsum_acc, r_nacc;
    logic [26:0]        wsum, r_nsum;
    logic [54:0]        xn;
    logic [DIV_N_W-1:0] r_dvd;
    logic [DIV_D_W-1:0] r_dvs;
    logic [DIV_Q_W-1:0] quo;
    t_value             r_pv [6];
    t_value             nval;

    always_comb begin
        psum     = '0;
        nsum_acc = '0;
        wsum     = '0;
        for (int k = 0; k < LANES; k++) begin
            psum     = psum + 53'(i_res[k].poly_pp);
            nsum_acc = nsum_acc + 52'(i_res[k].nna_pp);
            wsum     = wsum + 27'(i_res[k].nna_w);
        end
        pr = r_pacc + 53'sd8388608;
        // offset of sum * 2^25 keeps the dividend positive
        xn = (55'(r_nacc) << 1) + 55'(r_nsum) + (55'(r_nsum) << 25);
        nval = t_value'(26'(quo) - 26'(1 << 24));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pacc  <= psum;
            r_nacc  <= nsum_acc;
            r_nsum  <= wsum;
            r_pv[0] <= sat_val(pr[52:24]);
            for (int k = 1; k < 6; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
            r_dvd <= xn[DIV_N_W-1:0];
            r_dvs <= {r_nsum, 1'b0};
        end
    end

    fpi_div u_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_quotient (quo)
    );

    always_comb begin
        case (i_side.sel)
            SEL_POLY: o_value = r_pv[5];
            SEL_NNA:  o_value = nval;
            default:  o_value = i_side.val;
        endcase
    end

endmodule

`default_nettype wire

### hdl/four_point_sample_interpolator_top.sv
// ============================================================================
// four_point_sample_interpolator_top: four-point sample interpolator
// Throughput: one beat per cycle; the pipeline stalls only when the output
// register holds a beat that is not taken.
// Reset: synchronous, active low; clears the pipeline valid bits and sets
// interp_mode to linear and line_length to 256.
// ============================================================================
`default_nettype none

module four_point_sample_interpolator_top import fpi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // whole[15:0], fraction[31:16], before, at, after, after_two (24 each)
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // interpolated_value[25:0], zero pad
    output logic [OUT_W-1:0] m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]       m_axis_tuser,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        en, accept;
    logic        r_out_valid;
    logic [17:0] r_vld;
    t_value      r_out_val, merged;
    logic        r_out_oor;
    logic [2:0]  r_mode;
    logic [14:0] r_len;

    // stage 1
    logic signed [15:0] r1_l;
    logic [FRAC_W-1:0]  r1_r;
    t_sample            r1_s [LANES];
    logic signed [16:0] l17, len17;
    logic               oor, near_end;
    t_sample            nxt;
    logic signed [24:0] diff;
    logic [1:0]         n_sel;
    logic [2:0]         n_skind;
    logic [WGT_W-1:0]   t1;
    logic [47:0]        t1sq;

    // stage 2
    logic [1:0]         r2_sel;
    logic               r2_oor;
    logic [2:0]         r2_skind;
    t_sample            r2_at, r2_next;
    logic signed [41:0] r2_lin_n, lin_w;
    logic [WGT_W-1:0]   r2_t2, t1b;
    logic [FRAC_W-1:0]  r2_r;
    t_sample            r2_s [LANES];
    logic [1:0]         r2_kind;
    logic [47:0]        t3p;
    t_side              n_side;

    // stage 3 and on
    t_side     r3_side;
    t_lane_ctl r3_ctl;
    t_sample   r3_s [LANES];
    t_side     r_sdly [15];
    t_lane_res lres [LANES];

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_len  <= LEN_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LEN) begin
                r_len <= pwdata[14:0];
            end else begin
                r_mode <= pwdata[2:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_LEN) ? 32'(r_len) : 32'(r_mode);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[16:0], accept};
            r_out_valid <= r_vld[17];
        end
    end

    always_comb begin
        l17      = 17'(r1_l);
        len17    = $signed({2'b00, r_len});
        oor      = (l17 < 17'sd0) || (l17 >= len17);
        near_end = (l17 < 17'sd1) || (l17 >= len17 - 17'sd2);
        nxt      = ((l17 + 17'sd1) < len17) ? r1_s[2] : r1_s[1];
        diff     = 25'(nxt) - 25'(r1_s[1]);
        t1       = {r1_r, {(WGT_W-FRAC_W){1'b0}}};
        t1sq     = 48'(t1) * 48'(t1);
        n_sel    = SEL_SIMPLE;
        n_skind  = SV_ZERO;
        if (oor) begin
            n_skind = SV_NEG1;
        end else if (r_mode == MODE_ROUND) begin
            n_skind = r1_r[FRAC_W-1] ? SV_NEXT : SV_AT;
        end else if (r_mode inside {[MODE_LINEAR:MODE_NNA]}) begin
            if (r_mode == MODE_LINEAR || near_end) begin
                n_skind = (r1_r == '0) ? SV_AT : SV_LIN;
            end else if (r_mode == MODE_NNA) begin
                if (r1_r == '0) begin
                    n_skind = SV_AT;
                end else begin
                    n_sel = SEL_NNA;
                end
            end else begin
                n_sel = SEL_POLY;
            end
        end
    end

    always_comb begin
        lin_w = r2_lin_n + 42'sd32768;
        t1b   = {r2_r, {(WGT_W-FRAC_W){1'b0}}};
        t3p   = 48'(r2_t2) * 48'(t1b);
        n_side.sel = r2_sel;
        n_side.oor = r2_oor;
        case (r2_skind)
            SV_NEG1: n_side.val = '1;
            SV_AT:   n_side.val = VAL_W'(r2_at);
            SV_NEXT: n_side.val = VAL_W'(r2_next);
            SV_LIN:  n_side.val = lin_w[41:16];
            default: n_side.val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_l <= s_axis_tdata[15:0];
            r1_r <= s_axis_tdata[31:16];
            for (int k = 0; k < LANES; k++) begin
                r1_s[k] <= s_axis_tdata[32 + SAMP_W*k +: SAMP_W];
            end

            r2_sel   <= n_sel;
            r2_oor   <= oor;
            r2_skind <= n_skind;
            r2_at    <= r1_s[1];
            r2_next  <= nxt;
            r2_lin_n <= (42'(r1_s[1]) <<< FRAC_W)
                      + 42'($signed({1'b0, r1_r})) * 42'(diff);
            r2_t2    <= t1sq[47:24];
            r2_r     <= r1_r;
            r2_s     <= r1_s;
            r2_kind  <= 2'(r_mode - MODE_KEYS);

            r3_side     <= n_side;
            r3_ctl.frac <= r2_r;
            r3_ctl.t1   <= t1b;
            r3_ctl.t2   <= r2_t2;
            r3_ctl.t3   <= t3p[47:24];
            r3_ctl.kind <= r2_kind;
            r3_s        <= r2_s;

            r_sdly[0] <= r3_side;
            for (int k = 1; k < 15; k++) begin
                r_sdly[k] <= r_sdly[k-1];
            end

            r_out_val <= merged;
            r_out_oor <= r_sdly[14].oor;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fpi_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_lane   (2'(g)),
            .i_ctl    (r3_ctl),
            .i_sample (r3_s[g]),
            .o_res    (lres[g])
        );
    end

    fpi_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_res   (lres),
        .i_side  (r_sdly[14]),
        .o_value (merged)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-VAL_W){1'b0}}, r_out_val};
    assign m_axis_tuser  = r_out_oor;

endmodule

`default_nettype wire

### bench/fpi_result_checker.sv
// ============================================================================
// fpi_result_checker: result checker for the four-point sample interpolator
// Watches the APB writes, the input stream and the output stream. It keeps
// its own copy of the mode and line length registers and computes the
// expected value and range flag of every input beat. Each output beat is
// compared in order against the oldest expected result.
// ============================================================================
`default_nettype none

module fpi_result_checker import fpi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_out_data,
    input  logic [0:0]       i_out_user,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    input  logic             i_pready,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             oor;
    } t_interp_res;

    logic [2:0]  mode_q;
    logic [14:0] len_q;
    t_interp_res expected_q[$];
    int          err_cnt = 0;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic longint round_quot(longint n, longint d);
        return floor_quot(2 * n + d, 2 * d);
    endfunction

    function automatic longint lerp(longint a, longint b, longint r);
        return round_quot(a * 65536 + r * (b - a), 65536);
    endfunction

    function automatic longint cubic_eval(int kind, longint s[4], longint r);
        longint t1, t2, t3, num, acc;
        acc = 0;
        t1 = r << 8;
        t2 = (t1 * t1) >> 24;
        t3 = (t2 * t1) >> 24;
        for (int i = 0; i < 4; i++) begin
            num = longint'(POLY_C[kind][i][0]) * (64'sd1 << 24)
                + longint'(POLY_C[kind][i][1]) * t1
                + longint'(POLY_C[kind][i][2]) * t2
                + longint'(POLY_C[kind][i][3]) * t3;
            acc += round_quot(num, longint'(POLY_HALF[kind])) * s[i];
        end
        return round_quot(acc, 64'sd1 << 24);
    endfunction

    function automatic longint idw_eval(longint s[4], longint r);
        longint d[4];
        longint m, q, q2, q4, acc, wsum;
        acc = 0;
        wsum = 0;
        d[0] = 65536 + r;
        d[1] = r;
        d[2] = 65536 - r;
        d[3] = 131072 - r;
        m = (d[1] < d[2]) ? d[1] : d[2];
        for (int i = 0; i < 4; i++) begin
            q  = (m << 24) / d[i];
            q2 = (q * q) >> 24;
            q4 = (q2 * q2) >> 24;
            acc  += q4 * s[i];
            wsum += q4;
        end
        return round_quot(acc, wsum);
    endfunction

    function automatic t_interp_res interpolate(logic [IN_W-1:0] d, logic [2:0] mode,
                                                logic [14:0] len);
        t_interp_res res;
        longint l, r, n, v, nxt;
        longint s[4];
        logic near_end;
        l = longint'($signed(d[15:0]));
        r = longint'(d[31:16]);
        n = longint'(len);
        for (int i = 0; i < 4; i++) s[i] = longint'($signed(d[32+24*i +: 24]));
        nxt = (l + 1 < n) ? s[2] : s[1];
        res.oor = 1'b0;
        if (l < 0 || l >= n) begin
            v = -1;
            res.oor = 1'b1;
        end else if (mode == MODE_ROUND) begin
            v = (r >= 32768) ? nxt : s[1];
        end else if (mode >= MODE_LINEAR && mode <= MODE_NNA) begin
            near_end = (l < 1) || (l >= n - 2);
            if (mode == MODE_LINEAR || near_end) v = (r == 0) ? s[1] : lerp(s[1], nxt, r);
            else if (mode == MODE_NNA) v = (r == 0) ? s[1] : idw_eval(s, r);
            else v = cubic_eval(int'(mode - MODE_KEYS), s, r);
        end else begin
            v = 0;
        end
        if (v > 33554431) v = 33554431;
        if (v < -33554432) v = -33554432;
        res.val = v[VAL_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_interp_res exp_r;
        if (!i_rst_n) begin
            mode_q = MODE_LINEAR;
            len_q  = LEN_RESET;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_MODE) mode_q = i_pwdata[2:0];
                else len_q = i_pwdata[14:0];
            end
            if (i_in_valid && i_in_ready) expected_q.push_back(interpolate(i_in_data, mode_q, len_q));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected output beat: value %0d", $signed(i_out_data[VAL_W-1:0]));
                    err_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out_data[VAL_W-1:0] !== exp_r.val) begin
                        $error("interpolated_value: expected %0d, got %0d",
                               $signed(exp_r.val), $signed(i_out_data[VAL_W-1:0]));
                        err_cnt++;
                    end
                    if (i_out_user[0] !== exp_r.oor) begin
                        $error("out_of_range: expected %0b, got %0b", exp_r.oor, i_out_user[0]);
                        err_cnt++;
                    end
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expected_q.size();
    end

endmodule

`default_nettype wire

### bench/tb_four_point_sample_interpolator_top.sv
// ============================================================================
// tb_four_point_sample_interpolator_top: testbench of the interpolator
// Runs a series of mode and line length settings, each with a few directed
// beats at the edges followed by random positions and samples. Input bursts
// and output stalls are random; the checker predicts and compares.
// ============================================================================
`default_nettype none

module tb_four_point_sample_interpolator_top;
    import fpi_pkg::*;

    localparam int ITEMS_PER_PHASE = 121;
    localparam int NUM_PHASES      = 15;
    localparam int STALL_LIMIT     = 3000;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [0:0]       m_axis_tuser;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    int               errors;
    int               pending;
    int               idle_cycles;

    four_point_sample_interpolator_top dut (.*);

    fpi_result_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
    end

    // receiver: one long hold early on, then a changing stall pattern
    initial begin
        int cyc;
        int style;
        cyc = 0;
        style = 0;
        repeat (7) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) style = $urandom_range(0, 3);
            if (cyc >= 40 && cyc < 440) m_axis_tready <= 1'b0;
            else if (style == 0) m_axis_tready <= 1'b1;
            else if (style == 1) m_axis_tready <= $urandom_range(0, 1);
            else if (style == 2) m_axis_tready <= ($urandom_range(0, 7) != 0);
            else m_axis_tready <= ((cyc % 5) < 2);
        end
    end

    // watchdog on cycles without any beat
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    int burst_left;

    task automatic send_beat(logic [IN_W-1:0] d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 200)) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_whole(int len);
        int w;
        case ($urandom_range(0, 9))
            0: w = $signed(16'($urandom));
            9: case ($urandom_range(0, 6))
                   0: w = -1;
                   1: w = 0;
                   2: w = 1;
                   3: w = len - 3;
                   4: w = len - 2;
                   5: w = len - 1;
                   default: w = len;
               endcase
            default: w = int'($urandom_range(0, len + 3)) - 2;
        endcase
        if (w > 32767) w = 32767;
        if (w < -32768) w = -32768;
        return 16'(w);
    endfunction

    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [2:0]  modes [NUM_PHASES];
        int          lens  [NUM_PHASES];
        logic [15:0] whole;
        logic [15:0] frac;
        logic [23:0] s0, s1, s2, s3;
        logic [15:0] edge_whole [6];
        logic [15:0] edge_frac [5];

        modes = '{MODE_LINEAR, MODE_KEYS, MODE_BSPL, MODE_OMOMS, MODE_NNA, MODE_ROUND,
                  MODE_NONE, MODE_UNUSED, MODE_KEYS, MODE_OMOMS, MODE_NNA, MODE_BSPL,
                  MODE_LINEAR, MODE_NNA, MODE_ROUND};
        lens = '{256, 256, 256, 256, 256, 256, 256, 256, 3, 1, 2, 32767, 0, 4, 5};
        edge_frac = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
        burst_left = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
                apb_write(REG_MODE, 32'(modes[p]));
                apb_write(REG_LEN, 32'(lens[p]));
                repeat (2) @(posedge i_clk);
            end
            edge_whole = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                           16'(lens[p] - 1), 16'(lens[p] / 2)};
            // edges of position and sample range
            for (int k = 0; k < (p == 0 ? 24 : 8); k++) begin
                whole = edge_whole[k % 6];
                frac = edge_frac[k % 5];
                s0 = (k % 2) ? 24'h7FFFFF : 24'h800000;
                s1 = (k % 3) ? 24'h800000 : 24'h7FFFFF;
                s2 = (k % 4 < 2) ? 24'h7FFFFF : 24'h800000;
                s3 = (k % 2) ? 24'h800000 : 24'h7FFFFF;
                send_beat({s3, s2, s1, s0, frac, whole});
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                whole = pick_whole(lens[p]);
                frac = pick_fraction();
                s0 = pick_sample();
                s1 = pick_sample();
                s2 = pick_sample();
                s3 = pick_sample();
                send_beat({s3, s2, s1, s0, frac, whole});
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
